[design/tmlg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlg_pkg
// Shared widths, register indexes and the command record passed from the
// front end to the descriptor emitter.
// ----------------------------------------------------------------------------
package tmlg_pkg;

  localparam int EXT_W    = 13;  // matrix and tile extents
  localparam int LINE_W   = 12;  // line_index
  localparam int CB_W     = 4;   // cell_bytes
  localparam int TILE_W   = 18;  // tile_index
  localparam int SRC_W    = 27;  // source_offset
  localparam int STRIDE_W = 16;  // source_stride, run_bytes
  localparam int DST_W    = 15;  // target_offset
  localparam int CNT_W    = 7;   // tiles in one request, up to 64
  localparam int K_W      = 6;   // tile position along the line

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_BYTES   = 3'd4;

  // Configuration as the datapath sees it: saturated, tile sizes at least 1.
  typedef struct packed {
    logic [EXT_W-1:0] rows;
    logic [EXT_W-1:0] cols;
    logic [EXT_W-1:0] tw;
    logic [EXT_W-1:0] th;
    logic [CB_W-1:0]  cb;
  } cfg_t;

  // One request, fully worked out. Body fields serve every tile but the last
  // one on the line, tail fields serve the last one.
  typedef struct packed {
    logic                err;
    logic [CNT_W-1:0]    count;
    logic [TILE_W-1:0]   tile_base;
    logic [TILE_W-1:0]   tile_step;
    logic [DST_W-1:0]    dst_step;
    logic [SRC_W-1:0]    src_body;
    logic [SRC_W-1:0]    src_tail;
    logic [STRIDE_W-1:0] stride_body;
    logic [STRIDE_W-1:0] stride_tail;
    logic [STRIDE_W-1:0] run_body;
    logic [STRIDE_W-1:0] run_tail;
    logic [EXT_W-1:0]    runs_body;
    logic [EXT_W-1:0]    runs_tail;
  } cmd_t;

endpackage
`default_nettype wire

[design/tmlg_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlg_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder hold
// until the next go.
// ----------------------------------------------------------------------------
module tmlg_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      go,
  input  wire logic [tmlg_pkg::EXT_W-1:0] dividend,
  input  wire logic [tmlg_pkg::EXT_W-1:0] divisor,
  output logic                           done,
  output logic [tmlg_pkg::EXT_W-1:0]     quotient,
  output logic [tmlg_pkg::EXT_W-1:0]     remainder
);
  import tmlg_pkg::*;

  localparam int CNT_BITS = $clog2(EXT_W + 1);

  logic [EXT_W-1:0]    rem;
  logic [EXT_W-1:0]    quo;
  logic [EXT_W-1:0]    dvs;
  logic [CNT_BITS-1:0] cnt;
  logic                running;

  logic [EXT_W:0]   shifted;
  logic [EXT_W:0]   diff;
  logic [EXT_W-1:0] rem_next;
  logic [EXT_W-1:0] quo_next;

  always_comb begin
    shifted = {rem, quo[EXT_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[EXT_W]) begin
      rem_next = diff[EXT_W-1:0];
      quo_next = {quo[EXT_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[EXT_W-1:0];
      quo_next = {quo[EXT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && cnt == CNT_BITS'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CNT_BITS'(EXT_W);
    end else if (running) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt - CNT_BITS'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

[design/tmlg_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlg_front
// Takes a request, works out tile counts, line position and the byte figures
// by three divisions and seven multiply steps, and queues at most one command.
// ----------------------------------------------------------------------------
module tmlg_front #(
  parameter int MAX_TILES_PER_LINE = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       op,
  input  wire logic [tmlg_pkg::LINE_W-1:0] line_index,
  input  wire tmlg_pkg::cfg_t              cfg,
  input  wire logic                       full,
  output logic                            busy,
  output logic                            push,
  output tmlg_pkg::cmd_t                  cmd
);
  import tmlg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIVX  = 3'd1;
  localparam logic [2:0] ST_DIVY  = 3'd2;
  localparam logic [2:0] ST_DIVL  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;

  localparam logic [2:0] MUL_LAST = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // request and derived figures
  logic              mode;
  logic [LINE_W-1:0] line;
  logic [EXT_W-1:0]  tx;
  logic [EXT_W-1:0]  ty;
  logic [EXT_W-1:0]  lastw;
  logic [EXT_W-1:0]  lasth;
  logic [LINE_W-1:0] fixed;
  logic [LINE_W-1:0] pos;
  logic              err;
  logic [CNT_W-1:0]  span7;
  logic [2:0]        mstep;

  // products
  logic [TILE_W-1:0] tile_mul;
  logic [16:0]       wfull;
  logic [16:0]       wlast;
  logic [DST_W-1:0]  hstep;
  logic [SRC_W-1:0]  src_full;
  logic [SRC_W-1:0]  src_last;
  logic [SRC_W-1:0]  src_col;

  // divider
  logic             div_go;
  logic [EXT_W-1:0] div_dvd;
  logic [EXT_W-1:0] div_dvs;
  logic             div_done;
  logic [EXT_W-1:0] div_q;
  logic [EXT_W-1:0] div_r;

  logic [EXT_W-1:0] span;
  logic [EXT_W-1:0] limit;
  logic             chk_err;

  logic [16:0] mul_a;
  logic [12:0] mul_b;
  logic [29:0] prod;

  logic        edge_col;
  logic [16:0] col_width;

  tmlg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    div_go  = 1'b0;
    div_dvd = cfg.cols;
    div_dvs = cfg.tw;
    unique case (state)
      ST_IDLE: begin
        div_go = start;
      end
      ST_DIVX: begin
        div_go  = div_done;
        div_dvd = cfg.rows;
        div_dvs = cfg.th;
      end
      ST_DIVY: begin
        div_go  = div_done;
        div_dvd = {1'b0, line};
        div_dvs = mode ? cfg.tw : cfg.th;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  assign span    = mode ? ty : tx;
  assign limit   = mode ? cfg.cols : cfg.rows;
  assign chk_err = ({1'b0, line} >= limit) || (span > EXT_W'(MAX_TILES_PER_LINE));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_DIVX;
      ST_DIVX:  if (div_done) state_next = ST_DIVY;
      ST_DIVY:  if (div_done) state_next = ST_DIVL;
      ST_DIVL:  if (div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (chk_err) begin
          state_next = ST_PUSH;
        end else if (span == '0) begin
          state_next = ST_IDLE;  // line crosses no tile: nothing to emit
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   if (mstep == MUL_LAST) state_next = ST_PUSH;
      ST_PUSH:  if (!full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier, one product per step
  always_comb begin
    unique case (mstep)
      3'd0: begin
        mul_a = {5'b0, fixed};
        mul_b = tx;
      end
      3'd1: begin
        mul_a = {4'b0, cfg.tw};
        mul_b = {9'b0, cfg.cb};
      end
      3'd2: begin
        mul_a = {4'b0, lastw};
        mul_b = {9'b0, cfg.cb};
      end
      3'd3: begin
        mul_a = {4'b0, cfg.th};
        mul_b = {9'b0, cfg.cb};
      end
      3'd4: begin
        mul_a = wfull;
        mul_b = {1'b0, pos};
      end
      3'd5: begin
        mul_a = wlast;
        mul_b = {1'b0, pos};
      end
      3'd6: begin
        mul_a = {13'b0, cfg.cb};
        mul_b = {1'b0, pos};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 30'(mul_a) * 30'(mul_b);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      mode <= op;
      line <= line_index;
    end
    if (state == ST_DIVX && div_done) begin
      tx    <= div_q + EXT_W'(div_r != '0);
      lastw <= (div_r == '0) ? cfg.tw : div_r;
    end
    if (state == ST_DIVY && div_done) begin
      ty    <= div_q + EXT_W'(div_r != '0);
      lasth <= (div_r == '0) ? cfg.th : div_r;
    end
    if (state == ST_DIVL && div_done) begin
      fixed <= div_q[LINE_W-1:0];
      pos   <= div_r[LINE_W-1:0];
    end
    if (state == ST_CHECK) begin
      err   <= chk_err;
      span7 <= span[CNT_W-1:0];
      mstep <= '0;
    end
    if (state == ST_MUL) begin
      mstep <= mstep + 3'd1;
      unique case (mstep)
        3'd0:    tile_mul <= prod[TILE_W-1:0];
        3'd1:    wfull    <= prod[16:0];
        3'd2:    wlast    <= prod[16:0];
        3'd3:    hstep    <= prod[DST_W-1:0];
        3'd4:    src_full <= prod[SRC_W-1:0];
        3'd5:    src_last <= prod[SRC_W-1:0];
        3'd6:    src_col  <= prod[SRC_W-1:0];
        default: src_col  <= src_col;
      endcase
    end
  end

  // column mode: the fixed tile column is the right edge one
  assign edge_col  = ({1'b0, fixed} == (tx - EXT_W'(1)));
  assign col_width = edge_col ? wlast : wfull;

  always_comb begin
    cmd = '0;
    if (err) begin
      cmd.err   = 1'b1;
      cmd.count = CNT_W'(1);
    end else if (!mode) begin
      cmd.count       = span7;
      cmd.tile_base   = tile_mul;
      cmd.tile_step   = TILE_W'(1);
      cmd.dst_step    = wfull[DST_W-1:0];
      cmd.src_body    = src_full;
      cmd.src_tail    = src_last;
      cmd.stride_body = wfull[STRIDE_W-1:0];
      cmd.stride_tail = wlast[STRIDE_W-1:0];
      cmd.run_body    = wfull[STRIDE_W-1:0];
      cmd.run_tail    = wlast[STRIDE_W-1:0];
      cmd.runs_body   = EXT_W'(1);
      cmd.runs_tail   = EXT_W'(1);
    end else begin
      cmd.count       = span7;
      cmd.tile_base   = TILE_W'(fixed);
      cmd.tile_step   = TILE_W'(tx);
      cmd.dst_step    = hstep;
      cmd.src_body    = src_col;
      cmd.src_tail    = src_col;
      cmd.stride_body = col_width[STRIDE_W-1:0];
      cmd.stride_tail = col_width[STRIDE_W-1:0];
      cmd.run_body    = STRIDE_W'(cfg.cb);
      cmd.run_tail    = STRIDE_W'(cfg.cb);
      cmd.runs_body   = cfg.th;
      cmd.runs_tail   = lasth;
    end
  end

  assign push = (state == ST_PUSH) && !full;
  assign busy = (state != ST_IDLE);

endmodule
`default_nettype wire

[design/tmlg_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlg_queue
// Two-entry command queue. The head always sits in slot 0.
// ----------------------------------------------------------------------------
module tmlg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tmlg_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output tmlg_pkg::cmd_t     head
);
  import tmlg_pkg::*;

  cmd_t       slot0;
  cmd_t       slot1;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd1) begin
        slot0 <= push_cmd;
      end else begin
        slot0 <= slot1;
        slot1 <= push_cmd;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (fill == 2'd0) begin
        slot0 <= push_cmd;
      end else begin
        slot1 <= push_cmd;
      end
    end
  end

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slot0;

endmodule
`default_nettype wire

[design/tmlg_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlg_back
// Descriptor emitter: walks the tiles of one command, one descriptor a cycle,
// stepping the tile index and target offset by addition.
// ----------------------------------------------------------------------------
module tmlg_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  input  wire tmlg_pkg::cmd_t                head,
  output logic                               pop,
  output logic                               result_strobe,
  output logic [tmlg_pkg::TILE_W-1:0]        tile_index,
  output logic [tmlg_pkg::SRC_W-1:0]         source_offset,
  output logic [tmlg_pkg::STRIDE_W-1:0]      source_stride,
  output logic [tmlg_pkg::DST_W-1:0]         target_offset,
  output logic [tmlg_pkg::STRIDE_W-1:0]      run_bytes,
  output logic [tmlg_pkg::EXT_W-1:0]         run_count,
  output logic                               range_error,
  output logic                               final_item
);
  import tmlg_pkg::*;

  logic              active;
  cmd_t              cur;
  logic [K_W-1:0]    k;
  logic [TILE_W-1:0] tile_acc;
  logic [DST_W-1:0]  dst_acc;
  logic              last;

  assign last = ({1'b0, k} == (cur.count - CNT_W'(1)));
  assign pop  = cmd_valid && (!active || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head;
      k        <= '0;
      tile_acc <= head.tile_base;
      dst_acc  <= '0;
    end else if (active) begin
      k        <= k + K_W'(1);
      tile_acc <= tile_acc + cur.tile_step;
      dst_acc  <= dst_acc + cur.dst_step;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      tile_index    <= tile_acc;
      target_offset <= dst_acc;
      source_offset <= last ? cur.src_tail : cur.src_body;
      source_stride <= last ? cur.stride_tail : cur.stride_body;
      run_bytes     <= last ? cur.run_tail : cur.run_body;
      run_count     <= last ? cur.runs_tail : cur.runs_body;
      range_error   <= cur.err;
      final_item    <= last;
    end
  end

endmodule
`default_nettype wire

[design/tiled_matrix_line_gather_addresses_core.sv]
`default_nettype none
// Path of a request: three 13-step divisions, seven multiply steps, queue,
//   output register; a range error skips the multiply steps.
// The next request is taken once the front end is idle again, later while
//   the queue is full; one descriptor per cycle.
// Results cannot be stalled: each shows for one cycle under result_strobe.
// Reset: synchronous; queue emptied, configuration back to 1,1,1,1 and 4 bytes.
// ----------------------------------------------------------------------------
// tiled_matrix_line_gather_addresses_core
// Copy-descriptor generator for one row or column of a row-major tiled matrix.
// ----------------------------------------------------------------------------
module tiled_matrix_line_gather_addresses_core #(
  parameter int MAX_EXTENT         = 4096,
  parameter int MAX_TILES_PER_LINE = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           op,
  input  wire logic [tmlg_pkg::LINE_W-1:0]    line_index,
  // configuration write port
  input  wire logic                           cfg_write,
  input  wire logic [tmlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tmlg_pkg::EXT_W-1:0]     cfg_data,
  // descriptors
  output logic                                result_strobe,
  output logic [tmlg_pkg::TILE_W-1:0]         tile_index,
  output logic [tmlg_pkg::SRC_W-1:0]          source_offset,
  output logic [tmlg_pkg::STRIDE_W-1:0]       source_stride,
  output logic [tmlg_pkg::DST_W-1:0]          target_offset,
  output logic [tmlg_pkg::STRIDE_W-1:0]       run_bytes,
  output logic [tmlg_pkg::EXT_W-1:0]          run_count,
  output logic                                range_error,
  output logic                                final_item
);
  import tmlg_pkg::*;

  // Configuration registers, as written.
  logic [EXT_W-1:0] row_count;
  logic [EXT_W-1:0] column_count;
  logic [EXT_W-1:0] tile_width;
  logic [EXT_W-1:0] tile_height;
  logic [CB_W-1:0]  cell_bytes;

  cfg_t cfg;

  // front end to queue, queue to emitter
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;

  // Writes past the last register fall through and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= EXT_W'(1);
      column_count <= EXT_W'(1);
      tile_width   <= EXT_W'(1);
      tile_height  <= EXT_W'(1);
      cell_bytes   <= CB_W'(4);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        REG_TILE_WIDTH:   tile_width   <= cfg_data;
        REG_TILE_HEIGHT:  tile_height  <= cfg_data;
        REG_CELL_BYTES:   cell_bytes   <= cfg_data[CB_W-1:0];
        default:          cell_bytes   <= cell_bytes;
      endcase
    end
  end

  // Extents clamp to MAX_EXTENT; a zero tile size counts as one.
  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
    clamp_extent = (32'(v) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : v;
  endfunction

  function automatic logic [EXT_W-1:0] at_least_one(input logic [EXT_W-1:0] v);
    at_least_one = (v == '0) ? EXT_W'(1) : v;
  endfunction

  always_comb begin
    cfg.rows = clamp_extent(row_count);
    cfg.cols = clamp_extent(column_count);
    cfg.tw   = at_least_one(clamp_extent(tile_width));
    cfg.th   = at_least_one(clamp_extent(tile_height));
    cfg.cb   = cell_bytes;
  end

  // Front end: divisions, range check, byte figures. Error requests become a
  // single command with the error flag, count one and all else zero; a line
  // that crosses no tile (zero-sized matrix side) produces no command at all.
  tmlg_front #(
    .MAX_TILES_PER_LINE (MAX_TILES_PER_LINE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .line_index (line_index),
    .cfg        (cfg),
    .full       (q_full),
    .busy       (busy),
    .push       (q_push),
    .cmd        (q_push_cmd)
  );

  // Lets the front end take the next request while the emitter is still
  // walking the previous line.
  tmlg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Emitter: one transaction per tile, final_item on the last of each request.
  tmlg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_not_empty),
    .head          (q_head),
    .pop           (q_pop),
    .result_strobe (result_strobe),
    .tile_index    (tile_index),
    .source_offset (source_offset),
    .source_stride (source_stride),
    .target_offset (target_offset),
    .run_bytes     (run_bytes),
    .run_count     (run_count),
    .range_error   (range_error),
    .final_item    (final_item)
  );

endmodule
`default_nettype wire

[sim/tmlg_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmlg_tb_pkg
// Request codes shared by the line gather bench and its descriptor checker.
// ----------------------------------------------------------------------------
package tmlg_tb_pkg;

  typedef enum logic {
    OP_ROW    = 1'b0,
    OP_COLUMN = 1'b1
  } gather_op_t;

endpackage

[sim/tmlg_descriptor_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmlg_descriptor_checker
// Watches the request, register and descriptor ports, works out the copy
// descriptors of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module tmlg_descriptor_checker #(
  parameter int MAX_EXTENT         = 4096,
  parameter int MAX_TILES_PER_LINE = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic                           op,
  input  wire logic [tmlg_pkg::LINE_W-1:0]    line_index,
  input  wire logic                           cfg_write,
  input  wire logic [tmlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tmlg_pkg::EXT_W-1:0]     cfg_data,
  input  wire logic                           result_strobe,
  input  wire logic [tmlg_pkg::TILE_W-1:0]    tile_index,
  input  wire logic [tmlg_pkg::SRC_W-1:0]     source_offset,
  input  wire logic [tmlg_pkg::STRIDE_W-1:0]  source_stride,
  input  wire logic [tmlg_pkg::DST_W-1:0]     target_offset,
  input  wire logic [tmlg_pkg::STRIDE_W-1:0]  run_bytes,
  input  wire logic [tmlg_pkg::EXT_W-1:0]     run_count,
  input  wire logic                           range_error,
  input  wire logic                           final_item,
  output int                                  mismatch_count,
  output int                                  pending_descriptors,
  output int                                  requests_taken
);
  import tmlg_pkg::*;
  import tmlg_tb_pkg::*;

  typedef struct packed {
    logic [TILE_W-1:0]   tile_index;
    logic [SRC_W-1:0]    source_offset;
    logic [STRIDE_W-1:0] source_stride;
    logic [DST_W-1:0]    target_offset;
    logic [STRIDE_W-1:0] run_bytes;
    logic [EXT_W-1:0]    run_count;
    logic                range_error;
    logic                final_item;
  } descriptor_t;

  descriptor_t descriptor_q[$];

  // register copies, raw as written
  logic [EXT_W-1:0] rows_reg, cols_reg, tw_reg, th_reg;
  logic [CB_W-1:0]  cb_reg;

  function automatic longint unsigned clip_extent(logic [EXT_W-1:0] v);
    return (v > MAX_EXTENT) ? longint'(MAX_EXTENT) : longint'(v);
  endfunction

  function automatic void queue_descriptor(descriptor_t d);
    descriptor_q = {descriptor_q, d};
  endfunction

  function automatic void gather_descriptors(logic mode, logic [LINE_W-1:0] line);
    longint unsigned rows, cols, tw, th, cb, tiles_x, tiles_y, span, limit;
    longint unsigned fixed, pos, bx, by, aw, ah, k;
    descriptor_t d;
    rows = clip_extent(rows_reg);
    cols = clip_extent(cols_reg);
    tw   = clip_extent(tw_reg);
    th   = clip_extent(th_reg);
    if (tw == 0) tw = 1;
    if (th == 0) th = 1;
    cb      = cb_reg;
    tiles_x = (cols + tw - 1) / tw;
    tiles_y = (rows + th - 1) / th;
    span    = (mode == OP_COLUMN) ? tiles_y : tiles_x;
    limit   = (mode == OP_COLUMN) ? cols : rows;
    if (line >= limit || span > MAX_TILES_PER_LINE) begin
      d = '0;
      d.range_error = 1'b1;
      d.final_item  = 1'b1;
      queue_descriptor(d);
      return;
    end
    fixed = (mode == OP_COLUMN) ? line / tw : line / th;
    pos   = (mode == OP_COLUMN) ? line % tw : line % th;
    // an empty matrix in the other direction gives no descriptor at all
    for (k = 0; k < span; k++) begin
      bx = (mode == OP_COLUMN) ? fixed : k;
      by = (mode == OP_COLUMN) ? k : fixed;
      aw = cols - bx * tw;
      if (aw > tw) aw = tw;
      ah = rows - by * th;
      if (ah > th) ah = th;
      d.tile_index    = TILE_W'(by * tiles_x + bx);
      d.source_stride = STRIDE_W'(aw * cb);
      d.range_error   = 1'b0;
      d.final_item    = (k + 1 == span);
      if (mode == OP_COLUMN) begin
        d.source_offset = SRC_W'(pos * cb);
        d.target_offset = DST_W'(by * th * cb);
        d.run_bytes     = STRIDE_W'(cb);
        d.run_count     = EXT_W'(ah);
      end else begin
        d.source_offset = SRC_W'(pos * aw * cb);
        d.target_offset = DST_W'(bx * tw * cb);
        d.run_bytes     = STRIDE_W'(aw * cb);
        d.run_count     = EXT_W'(1);
      end
      queue_descriptor(d);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    descriptor_t want;
    if (rst) begin
      rows_reg = EXT_W'(1);
      cols_reg = EXT_W'(1);
      tw_reg   = EXT_W'(1);
      th_reg   = EXT_W'(1);
      cb_reg   = CB_W'(4);
      descriptor_q.delete();
    end else begin
      if (result_strobe) begin
        if (descriptor_q.size() == 0) begin
          $display("%0t: descriptor expected none, actual tile_index %0d range_error %0b",
                   $time, tile_index, range_error);
          mismatch_count++;
        end else begin
          want = descriptor_q.pop_front();
          check_field("tile_index", want.tile_index, tile_index);
          check_field("source_offset", want.source_offset, source_offset);
          check_field("source_stride", want.source_stride, source_stride);
          check_field("target_offset", want.target_offset, target_offset);
          check_field("run_bytes", want.run_bytes, run_bytes);
          check_field("run_count", want.run_count, run_count);
          check_field("range_error", want.range_error, range_error);
          check_field("final_item", want.final_item, final_item);
        end
      end
      if (start && !busy) begin
        gather_descriptors(op, line_index);
        requests_taken++;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT:    rows_reg = cfg_data;
          REG_COLUMN_COUNT: cols_reg = cfg_data;
          REG_TILE_WIDTH:   tw_reg   = cfg_data;
          REG_TILE_HEIGHT:  th_reg   = cfg_data;
          REG_CELL_BYTES:   cb_reg   = cfg_data[CB_W-1:0];
          default: ;
        endcase
      end
    end
    pending_descriptors = descriptor_q.size();
  end

endmodule

[sim/tb_tiled_matrix_line_gather_addresses_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiled_matrix_line_gather_addresses_core
// Drives row and column gather requests through a series of matrix and tile
// settings; the descriptor checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_tiled_matrix_line_gather_addresses_core;
  import tmlg_pkg::*;
  import tmlg_tb_pkg::*;

  localparam int MAX_EXTENT         = 4096;
  localparam int MAX_TILES_PER_LINE = 64;
  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  // quiet cycles after the last descriptor: covers the time that a
  // request yielding nothing keeps the front end busy
  localparam int SETTLE_CYCLES  = 120;
  // cycles with no transaction anywhere before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic                 busy;
  logic                 op         = 1'b0;
  logic [LINE_W-1:0]    line_index = '0;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [EXT_W-1:0]     cfg_data   = '0;
  logic                 result_strobe;
  logic [TILE_W-1:0]    tile_index;
  logic [SRC_W-1:0]     source_offset;
  logic [STRIDE_W-1:0]  source_stride;
  logic [DST_W-1:0]     target_offset;
  logic [STRIDE_W-1:0]  run_bytes;
  logic [EXT_W-1:0]     run_count;
  logic                 range_error;
  logic                 final_item;

  int mismatch_count;
  int pending_descriptors;
  int requests_taken;
  int idle_cycles = 0;

  // effective extents of the current setting, for picking in-range lines
  int rows_now = 1;
  int cols_now = 1;

  tiled_matrix_line_gather_addresses_core #(
    .MAX_EXTENT        (MAX_EXTENT),
    .MAX_TILES_PER_LINE(MAX_TILES_PER_LINE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .line_index   (line_index),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .tile_index   (tile_index),
    .source_offset(source_offset),
    .source_stride(source_stride),
    .target_offset(target_offset),
    .run_bytes    (run_bytes),
    .run_count    (run_count),
    .range_error  (range_error),
    .final_item   (final_item)
  );

  tmlg_descriptor_checker #(
    .MAX_EXTENT        (MAX_EXTENT),
    .MAX_TILES_PER_LINE(MAX_TILES_PER_LINE)
  ) u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .op                 (op),
    .line_index         (line_index),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .result_strobe      (result_strobe),
    .tile_index         (tile_index),
    .source_offset      (source_offset),
    .source_stride      (source_stride),
    .target_offset      (target_offset),
    .run_bytes          (run_bytes),
    .run_count          (run_count),
    .range_error        (range_error),
    .final_item         (final_item),
    .mismatch_count     (mismatch_count),
    .pending_descriptors(pending_descriptors),
    .requests_taken     (requests_taken)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any request, descriptor or register transaction resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // All tasks below are entered and left at a falling edge, so every input
  // changes on a falling edge, away from the sampling edge.

  // One request transaction. start stays high from the previous request when
  // there is no gap, so it is never dropped and raised in the same step.
  task automatic issue_request(input gather_op_t kind, input int line, input int gap);
    int goal;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    op         <= kind;
    line_index <= LINE_W'(line);
    goal = requests_taken + 1;
    // the checker counts the transaction at the edge that takes it
    do @(negedge clk); while (requests_taken != goal);
  endtask

  task automatic directed(input gather_op_t kind, input int line);
    issue_request(kind, line, $urandom_range(0, 8));
  endtask

  // Hold off until every descriptor owed has been seen, then idle a while.
  task automatic settle(input int extra);
    start <= 1'b0;
    while (pending_descriptors != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= EXT_W'(value);
    @(negedge clk);
  endtask

  // New matrix setting, written only once the core has gone quiet.
  task automatic apply_settings(input int rows, input int cols, input int tw,
                                input int th, input int cb);
    settle(SETTLE_CYCLES);
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                $urandom_range(0, 8191));
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
    write_reg(REG_CELL_BYTES, cb);
    cfg_write <= 1'b0;
    rows_now = (rows > MAX_EXTENT) ? MAX_EXTENT : rows;
    cols_now = (cols > MAX_EXTENT) ? MAX_EXTENT : cols;
  endtask

  // Mostly lines inside the matrix; now and then any 12-bit index.
  // Half way through the sender drains the core completely once.
  task automatic random_requests(input int count);
    gather_op_t kind;
    int         limit;
    int         line;
    bit         no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      kind  = gather_op_t'($urandom_range(0, 1));
      limit = (kind == OP_COLUMN) ? cols_now : rows_now;
      if (limit == 0 || $urandom_range(0, 7) == 0)
        line = $urandom_range(0, 4095);
      else
        line = $urandom_range(0, limit - 1);
      if (i == count / 2)
        settle(0);
      issue_request(kind, line, no_gaps ? 0 : $urandom_range(0, 8));
    end
  endtask

  function automatic int pick_extent();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(1, 64);
      1:       return MAX_EXTENT;
      default: return $urandom_range(1, MAX_EXTENT);
    endcase
  endfunction

  // Tile size giving 1..64 tiles along the extent, with the odd wild value
  // that may overflow the tile budget.
  function automatic int pick_tile(input int extent);
    int tiles;
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(1, MAX_EXTENT);
    tiles = $urandom_range(1, MAX_TILES_PER_LINE);
    return (extent + tiles - 1) / tiles;
  endfunction

  initial begin
    int rows, cols;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: a 1x1 matrix of one tile.
    directed(OP_ROW, 0);
    directed(OP_COLUMN, 0);
    directed(OP_ROW, 1);         // index out of range
    directed(OP_COLUMN, 4095);   // index out of range
    random_requests(8);

    // Full-size matrix, exactly the tile budget in both directions.
    apply_settings(4096, 4096, 64, 64, 8);
    directed(OP_ROW, 0);
    directed(OP_ROW, 4095);
    directed(OP_COLUMN, 4095);
    directed(OP_COLUMN, 2047);
    random_requests(8);

    // Row count above the limit saturates; rows span too many tiles.
    apply_settings(8191, 4096, 63, 4096, 15);
    directed(OP_ROW, 5);         // too many tiles on the line
    directed(OP_COLUMN, 4095);
    directed(OP_COLUMN, 0);
    random_requests(8);

    // Zero tile sizes act as one; zero rows: row requests fail, in-range
    // columns cross no tile and produce nothing.
    apply_settings(0, 40, 0, 0, 0);
    directed(OP_ROW, 0);
    directed(OP_COLUMN, 39);
    directed(OP_COLUMN, 40);
    random_requests(8);

    // Zero columns, the mirror case.
    apply_settings(50, 0, 7, 3, 2);
    directed(OP_COLUMN, 0);
    directed(OP_ROW, 49);
    random_requests(8);

    // Oversized tiles saturate; one tile, offsets wrap at their widths.
    apply_settings(4096, 4096, 8191, 8191, 15);
    directed(OP_ROW, 4095);
    directed(OP_COLUMN, 4095);
    directed(OP_ROW, 2048);
    random_requests(8);

    // Random settings, cell sizes mostly legal, sometimes anything.
    repeat (7) begin
      rows = pick_extent();
      cols = pick_extent();
      apply_settings(rows, cols, pick_tile(cols), pick_tile(rows),
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 8));
      random_requests(42);
    end

    settle(SETTLE_CYCLES);
    if (mismatch_count == 0 && pending_descriptors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[tiled_matrix_line_gather_addresses_core.f]
design/tmlg_pkg.sv
design/tmlg_div.sv
design/tmlg_front.sv
design/tmlg_queue.sv
design/tmlg_back.sv
design/tiled_matrix_line_gather_addresses_core.sv
sim/tmlg_tb_pkg.sv
sim/tmlg_descriptor_checker.sv
sim/tb_tiled_matrix_line_gather_addresses_core.sv
